/* sv/assert_macros.svh */
// Assertion macros shared by the RTL files of the decimal text unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* sv/sida_pkg.sv */
// Shared constants, hand-off type and digit helper for the decimal text unit.
`default_nettype none

package sida_pkg;

   localparam int ValueWidth     = 32;
   localparam int DigitWidth     = 4;
   localparam int DigitCount     = 10;
   localparam int BcdWidth       = DigitWidth * DigitCount;
   localparam int StepCountWidth = $clog2(ValueWidth);
   localparam int LeftWidth      = $clog2(DigitCount + 1);
   localparam int CharWidth      = 8;

   localparam logic [CharWidth-1:0] CharZero  = 8'd48;
   localparam logic [CharWidth-1:0] CharMinus = 8'd45;

   // Finished conversion waiting for the character stage.
   typedef struct packed {
      logic                valid;
      logic                negative;
      logic [BcdWidth-1:0] bcd;
   } conv_type;

   // Shift-and-add-3 correction of one BCD digit before it is doubled.
   function automatic logic [DigitWidth-1:0] dabble_adjust(input logic [DigitWidth-1:0] digit);
      logic [DigitWidth-1:0] result;
      result = (digit >= 4'd5) ? digit + 4'd3 : digit;
      return result;
   endfunction

endpackage

`default_nettype wire

/* sv/signed_int_to_decimal_ascii_unit.sv */
// Top level of the signed 32-bit integer to decimal ASCII text unit.
// Each accepted req_value word yields its decimal text on the rsp_ channel, one character per
// word, most significant first: an optional '-', then the digits with no leading zeros, and
// rsp_last set on the final digit. A bit-serial shift-and-add-3 converter loads the word and
// shifts the magnitude into ten BCD digits; the character stage then skips leading zeros and
// sends the digits one per cycle while rsp_ready is high. The converter takes the next word as
// soon as it has handed its digits over, so with rsp_ready held high the throughput of the
// unit is set by the 32-step converter loop.
`default_nettype none

module signed_int_to_decimal_ascii_unit (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_valid,
   output logic                                        req_ready,
   input  wire logic signed [sida_pkg::ValueWidth-1:0] req_value,
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_ready,
   output logic [sida_pkg::CharWidth-1:0]              rsp_character,
   output logic                                        rsp_last
);

   sida_pkg::conv_type conv;
   logic               conv_take;

   sida_dabble u_dabble (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_value (req_value),
      .conv      (conv),
      .conv_take (conv_take)
   );

   sida_emit u_emit (
      .clock         (clock),
      .reset         (reset),
      .conv          (conv),
      .conv_take     (conv_take),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_character (rsp_character),
      .rsp_last      (rsp_last)
   );

endmodule

`default_nettype wire

/* sv/sida_dabble.sv */
// Bit-serial binary to BCD converter: one magnitude bit shifted in per cycle.
`default_nettype none

module sida_dabble (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_valid,
   output logic                                        req_ready,
   input  wire logic signed [sida_pkg::ValueWidth-1:0] req_value,
   output sida_pkg::conv_type                          conv,
   input  wire logic                                   conv_take
);

   localparam logic [1:0] D_IDLE = 2'd0;
   localparam logic [1:0] D_CONV = 2'd1;
   localparam logic [1:0] D_HOLD = 2'd2;

   logic [1:0]                             state_ff, state_in;
   logic [sida_pkg::StepCountWidth-1:0]    step_ff, step_in;
   logic [sida_pkg::ValueWidth-1:0]        mag_ff, mag_in;
   logic [sida_pkg::BcdWidth-1:0]          bcd_ff, bcd_in;
   logic                                   neg_ff, neg_in;
   logic [sida_pkg::BcdWidth-1:0]          adjusted;
   logic                                   accept;
   logic                                   bcd_ok;

   assign req_ready = (state_ff == D_IDLE);
   assign accept    = req_valid && req_ready;

   always_comb begin
      for (int i = 0; i < sida_pkg::DigitCount; i++) begin
         adjusted[i*sida_pkg::DigitWidth +: sida_pkg::DigitWidth] =
            sida_pkg::dabble_adjust(bcd_ff[i*sida_pkg::DigitWidth +: sida_pkg::DigitWidth]);
      end
   end

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      mag_in   = mag_ff;
      bcd_in   = bcd_ff;
      neg_in   = neg_ff;
      case (state_ff)
         D_IDLE: begin
            if (accept) begin
               neg_in   = req_value[sida_pkg::ValueWidth-1];
               mag_in   = req_value[sida_pkg::ValueWidth-1] ?
                          ({sida_pkg::ValueWidth{1'b0}} - $unsigned(req_value)) :
                          $unsigned(req_value);
               bcd_in   = '0;
               step_in  = '0;
               state_in = D_CONV;
            end
         end
         D_CONV: begin
            bcd_in  = {adjusted[sida_pkg::BcdWidth-2:0], mag_ff[sida_pkg::ValueWidth-1]};
            mag_in  = {mag_ff[sida_pkg::ValueWidth-2:0], 1'b0};
            step_in = step_ff + 1'b1;
            if (step_ff == sida_pkg::StepCountWidth'(sida_pkg::ValueWidth - 1)) begin
               state_in = D_HOLD;
            end
         end
         D_HOLD: begin
            if (conv_take) begin
               state_in = D_IDLE;
            end
         end
         default: begin
            state_in = D_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= D_IDLE;
      end else begin
         state_ff <= state_in;
      end
      step_ff <= step_in;
      mag_ff  <= mag_in;
      bcd_ff  <= bcd_in;
      neg_ff  <= neg_in;
   end

   assign conv.valid    = (state_ff == D_HOLD);
   assign conv.negative = neg_ff;
   assign conv.bcd      = bcd_ff;

   always_comb begin
      bcd_ok = 1'b1;
      for (int i = 0; i < sida_pkg::DigitCount; i++) begin
         if (bcd_ff[i*sida_pkg::DigitWidth +: sida_pkg::DigitWidth] > 4'd9) begin
            bcd_ok = 1'b0;
         end
      end
   end

`include "assert_macros.svh"

   `ASSERT_SAME(a_bcd_digits_legal, conv.valid, bcd_ok, "BCD digit above nine at hand-off")
   `ASSERT_SAME(a_conv_after_full_shift, $rose(conv.valid), $past(accept, 33), "conversion length wrong")
   `ASSERT_NEXT(a_take_frees_converter, conv.valid && conv_take, req_ready, "converter not freed")

endmodule

`default_nettype wire

/* sv/sida_emit.sv */
// Character stage: skips leading zeros and sends sign and digits one per word.
`default_nettype none

module sida_emit (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire sida_pkg::conv_type                 conv,
   output logic                                    conv_take,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output logic [sida_pkg::CharWidth-1:0]          rsp_character,
   output logic                                    rsp_last
);

   localparam logic [1:0] E_IDLE  = 2'd0;
   localparam logic [1:0] E_SIGN  = 2'd1;
   localparam logic [1:0] E_SKIP  = 2'd2;
   localparam logic [1:0] E_DIGIT = 2'd3;

   logic [1:0]                           state_ff, state_in;
   logic [sida_pkg::BcdWidth-1:0]        digits_ff, digits_in;
   logic [sida_pkg::LeftWidth-1:0]       left_ff, left_in;
   logic                                 rsp_valid_ff, rsp_valid_in;
   logic [sida_pkg::CharWidth-1:0]       rsp_character_ff, rsp_character_in;
   logic                                 rsp_last_ff, rsp_last_in;
   logic                                 out_free;
   logic [sida_pkg::DigitWidth-1:0]      top_digit;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign top_digit = digits_ff[sida_pkg::BcdWidth-1 -: sida_pkg::DigitWidth];
   assign conv_take = (state_ff == E_IDLE) && conv.valid;

   always_comb begin
      state_in         = state_ff;
      digits_in        = digits_ff;
      left_in          = left_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_ready;
      rsp_character_in = rsp_character_ff;
      rsp_last_in      = rsp_last_ff;
      case (state_ff)
         E_IDLE: begin
            if (conv.valid) begin
               digits_in = conv.bcd;
               left_in   = sida_pkg::LeftWidth'(sida_pkg::DigitCount);
               state_in  = conv.negative ? E_SIGN : E_SKIP;
            end
         end
         E_SIGN: begin
            if (out_free) begin
               rsp_valid_in     = 1'b1;
               rsp_character_in = sida_pkg::CharMinus;
               rsp_last_in      = 1'b0;
               state_in         = E_SKIP;
            end
         end
         E_SKIP: begin
            // drop leading zeros, always keeping the units digit
            if (top_digit == '0 && left_ff > sida_pkg::LeftWidth'(1)) begin
               digits_in = {digits_ff[sida_pkg::BcdWidth-sida_pkg::DigitWidth-1:0],
                            {sida_pkg::DigitWidth{1'b0}}};
               left_in   = left_ff - 1'b1;
            end else begin
               state_in = E_DIGIT;
            end
         end
         E_DIGIT: begin
            if (out_free) begin
               rsp_valid_in     = 1'b1;
               rsp_character_in = sida_pkg::CharZero +
                                  {{(sida_pkg::CharWidth-sida_pkg::DigitWidth){1'b0}}, top_digit};
               rsp_last_in      = (left_ff == sida_pkg::LeftWidth'(1));
               digits_in        = {digits_ff[sida_pkg::BcdWidth-sida_pkg::DigitWidth-1:0],
                                   {sida_pkg::DigitWidth{1'b0}}};
               left_in          = left_ff - 1'b1;
               if (left_ff == sida_pkg::LeftWidth'(1)) begin
                  state_in = E_IDLE;
               end
            end
         end
         default: begin
            state_in = E_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= E_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      digits_ff        <= digits_in;
      left_ff          <= left_in;
      rsp_character_ff <= rsp_character_in;
      rsp_last_ff      <= rsp_last_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_character = rsp_character_ff;
   assign rsp_last      = rsp_last_ff;

`include "assert_macros.svh"

   `ASSERT_SAME(a_idle_word_is_last, rsp_valid_ff && state_ff == E_IDLE, rsp_last_ff,
                "run ended without last")
   `ASSERT_SAME(a_minus_not_last, rsp_valid_ff && rsp_character_ff == sida_pkg::CharMinus,
                !rsp_last_ff, "minus flagged last")
   `ASSERT_SAME(a_digits_left, state_ff == E_SKIP || state_ff == E_DIGIT, left_ff != '0,
                "no digit left")

endmodule

`default_nettype wire

/* dv/signed_int_to_decimal_ascii_unit_tb.sv */
// Self-checking testbench for the signed integer to decimal ASCII text unit.
`default_nettype none

module signed_int_to_decimal_ascii_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int              CycleLimit = 400000;
   localparam int              DrainWait  = 60;
   localparam logic [7:0]      AsciiZero  = 8'd48;
   localparam logic [7:0]      AsciiMinus = 8'd45;
   localparam logic [31:0]     MostNeg    = 32'h8000_0000;
   localparam logic [31:0]     MostPos    = 32'h7fff_ffff;

   typedef struct {
      logic [7:0] character;
      logic       last;
   } text_char_type;

   logic                                   clock = 1'b0;
   logic                                   reset = 1'b1;
   logic                                   req_valid = 1'b0;
   logic                                   req_ready;
   logic signed [sida_pkg::ValueWidth-1:0] req_value = '0;
   logic                                   rsp_valid;
   logic                                   rsp_ready = 1'b0;
   logic [sida_pkg::CharWidth-1:0]         rsp_character;
   logic                                   rsp_last;

   text_char_type pending_text[$];
   int            mismatches = 0;
   int            cycle_count = 0;
   int            send_idle_pct = 0;
   int            recv_stall_pct = 0;

   signed_int_to_decimal_ascii_unit uut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_value     (req_value),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_character (rsp_character),
      .rsp_last      (rsp_last)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CycleLimit) begin
         $display("signed_int_to_decimal_ascii_unit regression: fail");
         $finish;
      end
   end

   // Expected text of one word: optional minus, then digits without leading zeros.
   task automatic queue_decimal_text(input logic [31:0] value);
      logic          negative;
      logic [31:0]   magnitude;
      logic [3:0]    digits[10];
      int            ndigits;
      text_char_type tc;
      negative  = value[31];
      magnitude = negative ? 32'd0 - value : value;
      ndigits   = 0;
      do begin
         digits[ndigits] = 4'(magnitude % 10);
         magnitude       = magnitude / 10;
         ndigits++;
      end while (magnitude != 0 && ndigits < 10);
      if (negative) begin
         tc.character = AsciiMinus;
         tc.last      = 1'b0;
         pending_text.push_back(tc);
      end
      for (int i = ndigits - 1; i >= 0; i--) begin
         tc.character = AsciiZero + 8'(digits[i]);
         tc.last      = (i == 0);
         pending_text.push_back(tc);
      end
   endtask

   task automatic send_value(input logic [31:0] value);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_value <= value;
      do @(posedge clock); while (!req_ready);
      queue_decimal_text(value);
   endtask

   task automatic note_mismatch(input string what);
      mismatches++;
      if (mismatches <= 10) $display("mismatch at cycle %0d: %s", cycle_count, what);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      text_char_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_text.size() == 0) begin
            note_mismatch($sformatf("unexpected word char=%0d last=%0b",
                                    rsp_character, rsp_last));
         end else begin
            want = pending_text.pop_front();
            if (rsp_character !== want.character || rsp_last !== want.last)
               note_mismatch($sformatf("char exp %0d got %0d, last exp %0b got %0b",
                                       want.character, rsp_character, want.last, rsp_last));
         end
      end
   end

   task automatic test_zero_and_small();
      send_value(32'd0);
      send_value(32'd1);
      send_value(-32'sd1);
      send_value(32'd9);
      send_value(-32'sd9);
      send_value(32'd10);
      send_value(-32'sd10);
      send_value(32'd99);
      send_value(32'd100);
   endtask

   task automatic test_extremes();
      send_value(MostPos);
      send_value(MostNeg);
      send_value(MostNeg + 32'd1);
      send_value(32'hffff_ffff);
      send_value(32'h5555_5555);
      send_value(32'haaaa_aaaa);
   endtask

   // Digit-count boundaries around the ninth and tenth digit.
   task automatic test_digit_boundaries();
      send_value(32'd999_999_999);
      send_value(32'd1_000_000_000);
      send_value(-32'sd999_999_999);
      send_value(-32'sd1_000_000_000);
      send_value(32'd1_000_000_001);
      send_value(32'd123_456_789);
      send_value(-32'sd2_000_000_000);
   endtask

   task automatic test_random_values(input int count);
      longint lo, hi, magnitude, pow;
      int     ndigits;
      logic [31:0] value;
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(3) == 0) begin
            value = $urandom;
         end else begin
            // pick a digit count first so that short texts are as common as long ones
            ndigits = $urandom_range(1, 10);
            pow = 1;
            for (int d = 1; d < ndigits; d++) pow = pow * 10;
            lo = (ndigits == 1) ? 0 : pow;
            hi = pow * 10 - 1;
            if (hi > 64'd2147483647) hi = 64'd2147483647;
            magnitude = lo + (longint'({$urandom}) % (hi - lo + 1));
            value = 32'(magnitude);
            if ($urandom_range(1)) value = 32'd0 - value;
            if ($urandom_range(40) == 0) value = MostNeg;
         end
         send_value(value);
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_idle_pct  = 27;
      recv_stall_pct = 68;
      test_zero_and_small();
      test_extremes();
      test_digit_boundaries();
      test_random_values(75);

      send_idle_pct  = 68;
      recv_stall_pct = 27;
      test_random_values(75);

      send_idle_pct  = 0;
      recv_stall_pct = 0;
      test_random_values(75);
      test_extremes();

      req_valid <= 1'b0;
      while (pending_text.size() != 0) @(posedge clock);
      repeat (DrainWait) @(posedge clock);

      if (mismatches == 0 && pending_text.size() == 0) begin
         $display("signed_int_to_decimal_ascii_unit regression: pass");
      end else begin
         $display("signed_int_to_decimal_ascii_unit regression: fail");
      end
      $finish;
   end

endmodule

`default_nettype wire
